/* sv/non_blocking_cache_with_mshr_macros.svh */
// Assertion macros for the non-blocking cache.
`ifndef NON_BLOCKING_CACHE_WITH_MSHR_MACROS_SVH
`define NON_BLOCKING_CACHE_WITH_MSHR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define NBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define NBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/nbc_pkg.sv */
// Shared types, codes and byte-lane helpers of the non-blocking cache.
package nbc_pkg;

	localparam int ADDRESS_W = 32;
	localparam int DATA_W    = 64;
	localparam int PORT_ID_W = 8;

	typedef enum logic [1:0] {
		KIND_RESP    = 2'd0,
		KIND_WB      = 2'd1,
		KIND_FILL    = 2'd2,
		KIND_REFUSED = 2'd3
	} res_kind_t;

	localparam logic [1:0] LS_INVALID = 2'd0;
	localparam logic [1:0] LS_VALID   = 2'd1;
	localparam logic [1:0] LS_DIRTY   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_HIT,
		ST_WB,
		ST_FREQ,
		ST_FRD,
		ST_FFIN
	} state_t;

	function automatic logic [3:0] norm_size(input logic [3:0] sz);
		logic [3:0] r;
		case (sz)
			4'd1, 4'd2, 4'd4: r = sz;
			default:          r = 4'd8;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] size_mask(input logic [3:0] sz);
		logic [63:0] m;
		case (sz)
			4'd1:    m = 64'h0000_0000_0000_00FF;
			4'd2:    m = 64'h0000_0000_0000_FFFF;
			4'd4:    m = 64'h0000_0000_FFFF_FFFF;
			default: m = '1;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] lane_shift(input logic [2:0] a, input logic [3:0] sz);
		logic [3:0] m;
		logic [2:0] b;
		m = sz - 4'd1;
		b = a & ~m[2:0];
		return {b, 3'b000};
	endfunction

	function automatic logic [63:0] read_bytes(input logic [63:0] w, input logic [2:0] a,
			input logic [3:0] sz);
		return (w >> lane_shift(a, sz)) & size_mask(sz);
	endfunction

	function automatic logic [63:0] merge_bytes(input logic [63:0] w, input logic [63:0] d,
			input logic [2:0] a, input logic [3:0] sz);
		logic [5:0]  sh;
		logic [63:0] m;
		sh = lane_shift(a, sz);
		m  = size_mask(sz);
		return (w & ~(m << sh)) | ((d & m) << sh);
	endfunction

endpackage

/* sv/nbc_if.sv */
// Request and result channel interfaces of the non-blocking cache.
interface nbc_req_if import nbc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [ADDRESS_W-1:0] address;
	logic [3:0]           access_size;
	logic                 is_write;
	logic [DATA_W-1:0]    data_word;
	logic [PORT_ID_W-1:0] txn_id;
	logic [1:0]           beat_index;

	modport source(output valid, func, address, access_size, is_write, data_word,
		txn_id, beat_index, input ready);
	modport sink(input valid, func, address, access_size, is_write, data_word,
		txn_id, beat_index, output ready);
endinterface

interface nbc_rsp_if import nbc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           kind;
	logic [PORT_ID_W-1:0] out_id;
	logic [ADDRESS_W-1:0] mem_address;
	logic [DATA_W-1:0]    out_data;
	logic                 write_ack;
	logic [1:0]           out_beat;
	logic                 last;

	modport source(output valid, kind, out_id, mem_address, out_data, write_ack,
		out_beat, last, input ready);
	modport sink(input valid, kind, out_id, mem_address, out_data, write_ack,
		out_beat, last, output ready);
endinterface

/* sv/nbc_ram.sv */
// Generic simple dual-port RAM with registered read data.
module nbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

/* sv/non_blocking_cache_with_mshr.sv */
// Results: a refusal, a hit and a final fill beat each give one result; a miss gives a fill
// request, after LINE_BYTES/8 writeback beats when the victim is dirty; other fill beats give none.
// One transaction is taken at a time, and each result is held while rsp.ready is low.
// Reset: all lines invalid through one flip-flop per set, miss slots free,
// replacement LFSR seeded 0xACE1; no clearing pass.
`include "non_blocking_cache_with_mshr_macros.svh"

module non_blocking_cache_with_mshr import nbc_pkg::*; #(
	parameter int ADDR_BITS  = 32,
	parameter int LINE_BYTES = 32,
	parameter int WAYS       = 4,
	parameter int SETS       = 64,
	parameter int MSHRS      = 4,
	parameter int ID_BITS    = 8
) (
	input logic       clk,
	input logic       arst_n,
	nbc_req_if.sink   req,
	nbc_rsp_if.source rsp
);
	localparam int LB     = $clog2(LINE_BYTES);
	localparam int SB     = $clog2(SETS);
	localparam int WPL    = LINE_BYTES / 8;
	localparam int WPLB   = (WPL > 1) ? $clog2(WPL) : 1;
	localparam int TAGW   = ADDR_BITS - LB - SB;
	localparam int WAYB   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOTB  = (MSHRS > 1) ? $clog2(MSHRS) : 1;
	localparam int IDW    = (ID_BITS < PORT_ID_W) ? ID_BITS : PORT_ID_W;
	localparam int ENT    = 2 + TAGW;
	localparam int ROWW   = WAYS * ENT;
	localparam int DDEPTH = SETS * WAYS * WPL;
	localparam int DAB    = $clog2(DDEPTH);
	localparam int RECIP  = ((1 << 21) + WAYS - 1) / WAYS;

	function automatic logic [DAB-1:0] daddr(input logic [SB-1:0] s, input logic [WAYB-1:0] w,
			input logic [WPLB-1:0] k);
		return DAB'((int'(s) * WAYS + int'(w)) * WPL + int'(k));
	endfunction

	function automatic logic [WPLB-1:0] wsel(input logic [ADDR_BITS-1:0] a);
		return WPLB'(a >> 3) & WPLB'(WPL - 1);
	endfunction

	state_t st_q, st_d;

	logic                 func_q, wr_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [3:0]           sz_q;
	logic [63:0]          d_q;
	logic [IDW-1:0]       id_q;
	logic [WPLB-1:0]      beat_q;

	logic [MSHRS-1:0]     busy_q;
	logic [IDW-1:0]       sid_q   [MSHRS];
	logic [ADDR_BITS-1:0] saddr_q [MSHRS];
	logic [3:0]           ssz_q   [MSHRS];
	logic                 swr_q   [MSHRS];
	logic [63:0]          swd_q   [MSHRS];
	logic [SB-1:0]        sset_q  [MSHRS];
	logic [WAYB-1:0]      sway_q  [MSHRS];
	logic                 stalled_q;
	logic [SLOTB-1:0]     ms_q;

	logic [15:0]          lfsr_q, quo_q;
	logic [WAYB-1:0]      hw_q, vw_q;
	logic [ADDR_BITS-1:0] wba_q;
	logic [WPLB-1:0]      wb_q;

	logic [SETS-1:0]      setv_q;
	logic [SB-1:0]        rset_q;

	logic                 ov_q, last_q, ack_q;
	res_kind_t            kind_q;
	logic [IDW-1:0]       oid_q;
	logic [ADDR_BITS-1:0] oaddr_q;
	logic [63:0]          odata_q;
	logic [WPLB-1:0]      obeat_q;

	logic                 srd_en, swe, tag_we;
	logic [SB-1:0]        srd_addr;
	logic [ROWW-1:0]      srow, swdata;
	logic [WAYB-1:0]      row_way;
	logic [1:0]           row_st;
	logic [TAGW-1:0]      row_tag;
	logic                 dre, dwe;
	logic [DAB-1:0]       dra, dwa;
	logic [63:0]          drdata, dwd;

	logic                 emit, e_last, e_ack;
	res_kind_t            e_kind;
	logic [IDW-1:0]       e_id;
	logic [ADDR_BITS-1:0] e_addr;
	logic [63:0]          e_data;
	logic [WPLB-1:0]      e_beat;

	logic [ADDR_BITS-1:0] addr_in;
	logic [SB-1:0]        set_a;
	logic [TAGW-1:0]      tag_a;
	logic [1:0]           st_w [WAYS];
	logic [TAGW-1:0]      tg_w [WAYS];
	logic                 rowv, hit_f, vic_f, fm_hit, can_emit;
	logic [WAYB-1:0]      hit_w, vic_w, lway, vway;
	logic [SLOTB-1:0]     fm_idx, free_idx;
	logic [MSHRS-1:0]     busy_after;

	assign addr_in  = ADDR_BITS'(req.address);
	assign set_a    = addr_q[LB +: SB];
	assign tag_a    = addr_q[ADDR_BITS-1 -: TAGW];
	assign can_emit = !ov_q || rsp.ready;
	assign req.ready = (st_q == ST_IDLE);
	assign rowv     = setv_q[rset_q];
	assign lway     = WAYB'(lfsr_q - 16'(quo_q * 16'(WAYS)));
	assign vway     = vic_f ? vic_w : lway;

	nbc_ram #(.WIDTH(ROWW), .DEPTH(SETS)) u_set_ram (
		.clk   (clk),
		.re    (srd_en),
		.raddr (srd_addr),
		.rdata (srow),
		.we    (swe),
		.waddr (rset_q),
		.wdata (swdata)
	);

	nbc_ram #(.WIDTH(64), .DEPTH(DDEPTH)) u_data_ram (
		.clk   (clk),
		.re    (dre),
		.raddr (dra),
		.rdata (drdata),
		.we    (dwe),
		.waddr (dwa),
		.wdata (dwd)
	);

	always_comb begin
		hit_f = 1'b0;
		hit_w = '0;
		vic_f = 1'b0;
		vic_w = '0;
		for (int w = 0; w < WAYS; w++) begin
			st_w[w] = rowv ? srow[w*ENT+TAGW +: 2] : LS_INVALID;
			tg_w[w] = srow[w*ENT +: TAGW];
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (st_w[w] != LS_INVALID && tg_w[w] == tag_a) begin
				hit_f = 1'b1;
				hit_w = WAYB'(w);
			end
			if (st_w[w] != LS_DIRTY) begin
				vic_f = 1'b1;
				vic_w = WAYB'(w);
			end
		end
	end

	always_comb begin
		fm_hit   = 1'b0;
		fm_idx   = '0;
		free_idx = SLOTB'(MSHRS - 1);
		for (int i = 0; i < MSHRS; i++)
			if (busy_q[i] && sid_q[i] == id_q) begin
				fm_hit = 1'b1;
				fm_idx = SLOTB'(i);
			end
		for (int i = MSHRS - 1; i >= 0; i--)
			if (!busy_q[i])
				free_idx = SLOTB'(i);
		busy_after = busy_q;
		busy_after[free_idx] = 1'b1;
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++)
			if (WAYB'(w) == row_way)
				swdata[w*ENT +: ENT] = {row_st, tag_we ? row_tag : tg_w[w]};
			else
				swdata[w*ENT +: ENT] = {st_w[w], tg_w[w]};
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:
				if (req.valid)
					st_d = ST_LOOK;
			ST_LOOK:
				if (func_q) begin
					if (fm_hit && beat_q == WPLB'(WPL - 1))
						st_d = ST_FRD;
					else
						st_d = ST_IDLE;
				end else if (stalled_q) begin
					if (can_emit)
						st_d = ST_IDLE;
				end else if (hit_f) begin
					st_d = ST_HIT;
				end else if (vic_f) begin
					st_d = ST_FREQ;
				end else begin
					st_d = ST_WB;
				end
			ST_HIT, ST_FREQ, ST_FFIN:
				if (can_emit)
					st_d = ST_IDLE;
			ST_WB:
				if (can_emit && wb_q == WPLB'(WPL - 1))
					st_d = ST_FREQ;
			ST_FRD:
				st_d = ST_FFIN;
			default:
				st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		srd_en   = 1'b0;
		srd_addr = addr_in[LB +: SB];
		swe      = 1'b0;
		tag_we   = 1'b0;
		row_way  = '0;
		row_st   = LS_INVALID;
		row_tag  = saddr_q[ms_q][ADDR_BITS-1 -: TAGW];
		dre      = 1'b0;
		dra      = '0;
		dwe      = 1'b0;
		dwa      = '0;
		dwd      = d_q;
		emit     = 1'b0;
		e_kind   = KIND_RESP;
		e_id     = id_q;
		e_addr   = '0;
		e_data   = '0;
		e_ack    = 1'b0;
		e_beat   = '0;
		e_last   = 1'b0;
		case (st_q)
			ST_IDLE:
				srd_en = req.valid;
			ST_LOOK:
				if (func_q) begin
					if (fm_hit) begin
						dwe = 1'b1;
						dwa = daddr(sset_q[fm_idx], sway_q[fm_idx], beat_q);
						if (beat_q == WPLB'(WPL - 1)) begin
							srd_en   = 1'b1;
							srd_addr = sset_q[fm_idx];
						end
					end
				end else if (stalled_q) begin
					emit   = can_emit;
					e_kind = KIND_REFUSED;
					e_last = 1'b1;
				end else if (hit_f) begin
					dre = 1'b1;
					dra = daddr(set_a, hit_w, wsel(addr_q));
				end else begin
					swe     = 1'b1;
					row_way = vway;
					row_st  = LS_INVALID;
					if (!vic_f) begin
						dre = 1'b1;
						dra = daddr(set_a, lway, '0);
					end
				end
			ST_HIT:
				if (can_emit) begin
					emit   = 1'b1;
					e_ack  = wr_q;
					e_last = 1'b1;
					e_data = wr_q ? 64'd0 : read_bytes(drdata, addr_q[2:0], sz_q);
					if (wr_q) begin
						dwe     = 1'b1;
						dwa     = daddr(set_a, hw_q, wsel(addr_q));
						dwd     = merge_bytes(drdata, d_q, addr_q[2:0], sz_q);
						swe     = 1'b1;
						row_way = hw_q;
						row_st  = LS_DIRTY;
					end
				end
			ST_WB:
				if (can_emit) begin
					emit   = 1'b1;
					e_kind = KIND_WB;
					e_addr = wba_q;
					e_data = drdata;
					e_beat = wb_q;
					if (wb_q != WPLB'(WPL - 1)) begin
						dre = 1'b1;
						dra = daddr(set_a, vw_q, wb_q + WPLB'(1));
					end
				end
			ST_FREQ:
				if (can_emit) begin
					emit   = 1'b1;
					e_kind = KIND_FILL;
					e_addr = {addr_q[ADDR_BITS-1:LB], LB'(0)};
					e_last = 1'b1;
				end
			ST_FRD: begin
				dre = 1'b1;
				dra = daddr(sset_q[ms_q], sway_q[ms_q], wsel(saddr_q[ms_q]));
			end
			ST_FFIN:
				if (can_emit) begin
					emit    = 1'b1;
					e_id    = sid_q[ms_q];
					e_ack   = swr_q[ms_q];
					e_last  = 1'b1;
					e_data  = swr_q[ms_q] ? 64'd0 :
						read_bytes(drdata, saddr_q[ms_q][2:0], ssz_q[ms_q]);
					swe     = 1'b1;
					tag_we  = 1'b1;
					row_way = sway_q[ms_q];
					row_st  = swr_q[ms_q] ? LS_DIRTY : LS_VALID;
					if (swr_q[ms_q]) begin
						dwe = 1'b1;
						dwa = daddr(sset_q[ms_q], sway_q[ms_q], wsel(saddr_q[ms_q]));
						dwd = merge_bytes(drdata, swd_q[ms_q], saddr_q[ms_q][2:0],
							ssz_q[ms_q]);
					end
				end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			busy_q    <= '0;
			stalled_q <= 1'b0;
			lfsr_q    <= 16'hACE1;
			quo_q     <= '0;
			wb_q      <= '0;
			setv_q    <= '0;
			ov_q      <= 1'b0;
		end else begin
			st_q  <= st_d;
			quo_q <= 16'((40'(lfsr_q) * 40'(RECIP)) >> 21);
			if (swe)
				setv_q[rset_q] <= 1'b1;
			if (st_q == ST_LOOK && !func_q && !stalled_q && !hit_f && !vic_f)
				lfsr_q <= {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
			if (st_q == ST_WB && can_emit)
				wb_q <= (wb_q == WPLB'(WPL - 1)) ? '0 : wb_q + WPLB'(1);
			if (st_q == ST_FREQ && can_emit) begin
				busy_q[free_idx] <= 1'b1;
				stalled_q        <= &busy_after;
			end
			if (st_q == ST_FFIN && can_emit) begin
				busy_q[ms_q] <= 1'b0;
				stalled_q    <= 1'b0;
			end
			if (emit)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q <= req.func;
			addr_q <= addr_in;
			sz_q   <= norm_size(req.access_size);
			wr_q   <= req.is_write;
			d_q    <= req.data_word;
			id_q   <= IDW'(req.txn_id);
			beat_q <= WPLB'(req.beat_index) & WPLB'(WPL - 1);
		end
		if (srd_en)
			rset_q <= srd_addr;
		if (st_q == ST_LOOK) begin
			ms_q  <= fm_idx;
			hw_q  <= hit_w;
			vw_q  <= vway;
			wba_q <= {tg_w[vway], set_a, LB'(0)};
		end
		if (st_q == ST_FREQ && can_emit) begin
			sid_q[free_idx]   <= id_q;
			saddr_q[free_idx] <= addr_q;
			ssz_q[free_idx]   <= sz_q;
			swr_q[free_idx]   <= wr_q;
			swd_q[free_idx]   <= d_q;
			sset_q[free_idx]  <= set_a;
			sway_q[free_idx]  <= vw_q;
		end
		if (emit) begin
			kind_q  <= e_kind;
			oid_q   <= e_id;
			oaddr_q <= e_addr;
			odata_q <= e_data;
			ack_q   <= e_ack;
			obeat_q <= e_beat;
			last_q  <= e_last;
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.kind        = kind_q;
	assign rsp.out_id      = PORT_ID_W'(oid_q);
	assign rsp.mem_address = ADDRESS_W'(oaddr_q);
	assign rsp.out_data    = odata_q;
	assign rsp.write_ack   = ack_q;
	assign rsp.out_beat    = 2'(obeat_q);
	assign rsp.last        = last_q;

	`NBC_ASSERT_NOW(a_stall_full, stalled_q, &busy_q, "stalled with a free miss slot")
	`NBC_ASSERT_NEXT(a_fill_req_last, st_q == ST_FREQ && can_emit,
		st_q == ST_IDLE && rsp.valid && rsp.last, "fill request not final")
	`NBC_ASSERT_NOW(a_wb_beat_idle, wb_q != '0, st_q == ST_WB, "writeback beat count stale")
endmodule
